// ===== hw/rtl/voxel_face_cull_ambient_occlusion_unit_macros.svh =====
// assertion macros for the voxel face cull / ambient occlusion unit
// no dependencies; included by files that carry concurrent checks
`ifndef VOXEL_FACE_CULL_AMBIENT_OCCLUSION_UNIT_MACROS_SVH
`define VOXEL_FACE_CULL_AMBIENT_OCCLUSION_UNIT_MACROS_SVH

`ifndef SYNTH

// property that must hold on every clock edge out of reset
`define VXAO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vxao check failed");

// consequence that must hold in the cycle after the antecedent
`define VXAO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vxao check failed");

`else

`define VXAO_ASSERT(lbl, prop)
`define VXAO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/vxao_pkg.sv =====
// shared constants, types and neighbour tables for the voxel face cull unit
// no dependencies
package vxao_pkg;

    localparam int KIND_BITS    = 16;
    localparam int POS_BITS     = 24;
    localparam int FACES        = 6;
    localparam int FACE_BITS    = 3;
    localparam int CORNERS      = 4;
    localparam int CORNER_CELLS = 3;
    localparam int NB_CELLS     = 27;
    localparam int NB_IDX_BITS  = 5;
    localparam int LEVEL_BITS   = 8;
    localparam int CODE_BITS    = 2;
    localparam int REG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_ZERO  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_ONE   = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_TWO   = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_THREE = 2'd3;

    // reset brightness levels, scaled by 255
    localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO_RST  = 8'd255;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE_RST   = 8'd179;
    localparam logic [LEVEL_BITS-1:0] LEVEL_TWO_RST   = 8'd115;
    localparam logic [LEVEL_BITS-1:0] LEVEL_THREE_RST = 8'd26;

    // corner occlusion codes
    localparam logic [CODE_BITS-1:0] AO_CODE_NONE = 2'd0;
    localparam logic [CODE_BITS-1:0] AO_CODE_ONE  = 2'd1;
    localparam logic [CODE_BITS-1:0] AO_CODE_TWO  = 2'd2;
    localparam logic [CODE_BITS-1:0] AO_CODE_FULL = 2'd3;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] zero;
        logic [LEVEL_BITS-1:0] one;
        logic [LEVEL_BITS-1:0] two;
        logic [LEVEL_BITS-1:0] three;
    } vxao_levels_t;

    // face neighbour cell per face, order +X -X +Y -Y +Z -Z
    localparam logic [NB_IDX_BITS-1:0] FACE_NB [FACES] = '{
        5'd14, 5'd12, 5'd22, 5'd4, 5'd16, 5'd10
    };

    // per face and corner: edge cell, edge cell, corner cell
    localparam logic [NB_IDX_BITS-1:0] CORNER_NB [FACES][CORNERS][CORNER_CELLS] = '{
        '{ '{5'd5,  5'd11, 5'd2},  '{5'd23, 5'd11, 5'd20},
           '{5'd23, 5'd17, 5'd26}, '{5'd5,  5'd17, 5'd8}  },
        '{ '{5'd3,  5'd15, 5'd6},  '{5'd21, 5'd15, 5'd24},
           '{5'd21, 5'd9,  5'd18}, '{5'd3,  5'd9,  5'd0}  },
        '{ '{5'd21, 5'd19, 5'd18}, '{5'd21, 5'd25, 5'd24},
           '{5'd23, 5'd25, 5'd26}, '{5'd23, 5'd19, 5'd20} },
        '{ '{5'd3,  5'd7,  5'd6},  '{5'd3,  5'd1,  5'd0},
           '{5'd5,  5'd1,  5'd2},  '{5'd5,  5'd7,  5'd8}  },
        '{ '{5'd7,  5'd17, 5'd8},  '{5'd25, 5'd17, 5'd26},
           '{5'd25, 5'd15, 5'd24}, '{5'd7,  5'd15, 5'd6}  },
        '{ '{5'd1,  5'd9,  5'd0},  '{5'd19, 5'd9,  5'd18},
           '{5'd19, 5'd11, 5'd20}, '{5'd1,  5'd11, 5'd2}  }
    };

endpackage

// ===== hw/rtl/vxao_face_shade.sv =====
// corner occlusion codes and quad diagonal choice for one face
// depends on vxao_pkg
module vxao_face_shade
(
    input  logic [vxao_pkg::FACE_BITS-1:0]  face,
    input  logic [vxao_pkg::NB_CELLS-1:0]   nmask,
    input  vxao_pkg::vxao_levels_t          levels,
    output logic [vxao_pkg::CORNERS*vxao_pkg::CODE_BITS-1:0] ao_codes,
    output logic                            flip_diagonal
);
    import vxao_pkg::*;

    logic [CORNERS*CORNER_CELLS-1:0] cells;
    logic [CODE_BITS-1:0]            code [CORNERS];
    logic [LEVEL_BITS-1:0]           lvl  [CORNERS];
    logic [LEVEL_BITS:0]             sum_even;
    logic [LEVEL_BITS:0]             sum_odd;

    // gather the edge and corner cells of every corner of the selected face
    always_comb
    begin
        cells = '0;
        for (int f = 0; f < FACES; f++)
        begin
            if (face == FACE_BITS'(f))
            begin
                for (int k = 0; k < CORNERS; k++)
                begin
                    for (int j = 0; j < CORNER_CELLS; j++)
                    begin
                        cells[k*CORNER_CELLS+j] = nmask[CORNER_NB[f][k][j]];
                    end
                end
            end
        end
    end

    // per corner code and its brightness level
    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            if (cells[k*CORNER_CELLS] && cells[k*CORNER_CELLS+1])
            begin
                code[k] = AO_CODE_FULL;
            end
            else
            begin
                code[k] = {1'b0, cells[k*CORNER_CELLS]}
                        + {1'b0, cells[k*CORNER_CELLS+1]}
                        + {1'b0, cells[k*CORNER_CELLS+2]};
            end
            case (code[k])
                AO_CODE_NONE: lvl[k] = levels.zero;
                AO_CODE_ONE:  lvl[k] = levels.one;
                AO_CODE_TWO:  lvl[k] = levels.two;
                default:      lvl[k] = levels.three;
            endcase
        end
    end

    // diagonal choice: split along the brighter pair
    assign sum_even = {1'b0, lvl[0]} + {1'b0, lvl[2]};
    assign sum_odd  = {1'b0, lvl[1]} + {1'b0, lvl[3]};
    assign flip_diagonal = !(sum_even > sum_odd);

    assign ao_codes = {code[3], code[2], code[1], code[0]};

endmodule

// ===== hw/rtl/voxel_face_cull_ambient_occlusion_unit.sv =====
// top level of the voxel face cull and corner ambient occlusion unit
// depends on vxao_pkg, vxao_face_shade and the unit's assertion macros
//
// usage
//   in channel (in_valid / in_ready): one voxel request with position, id,
//   block flags, 27 neighbour solid bits and six face transparent bits
//   out channel (out_valid / out_ready): one request per visible face, in
//   face order +X -X +Y -Y +Z -Z, last_face marking the voxel's last one
//   cfg port: cfg_write with cfg_index 0..3 loads one brightness level;
//   write only while both channels are quiet
// timing
//   a voxel is registered with its visible-face mask; one face is shaded
//   per cycle, while the output is not stalled, into the output register,
//   so the first face passes the hold stage and then the output register;
//   a voxel stays in the hold stage until its last visible face issues
//   (culled voxels go through at one per cycle, single-face voxels too while
//   the output is not stalled); the next voxel is taken in the cycle that issues the current last face
// reset and stall
//   reset empties both registers and restores the default levels
//   a stalled output register holds its face and freezes the face mask
`include "voxel_face_cull_ambient_occlusion_unit_macros.svh"

module voxel_face_cull_ambient_occlusion_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // voxel requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vxao_pkg::POS_BITS-1:0] world_x,
    input  logic signed [vxao_pkg::POS_BITS-1:0] world_y,
    input  logic signed [vxao_pkg::POS_BITS-1:0] world_z,
    input  logic [vxao_pkg::KIND_BITS-1:0]      block_kind,
    input  logic                                is_air,
    input  logic                                is_solid,
    input  logic                                is_transparent,
    input  logic                                is_cube,
    input  logic                                has_glow,
    input  logic [vxao_pkg::NB_CELLS-1:0]       neighbour_solid_mask,
    input  logic [vxao_pkg::FACES-1:0]          face_transparent_mask,
    // face requests
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vxao_pkg::POS_BITS-1:0] out_x,
    output logic signed [vxao_pkg::POS_BITS-1:0] out_y,
    output logic signed [vxao_pkg::POS_BITS-1:0] out_z,
    output logic [vxao_pkg::KIND_BITS-1:0]      out_kind,
    output logic [vxao_pkg::FACE_BITS-1:0]      face,
    output logic [vxao_pkg::CORNERS*vxao_pkg::CODE_BITS-1:0] ao_codes,
    output logic                                flip_diagonal,
    output logic                                out_transparent,
    output logic                                out_glow,
    output logic                                last_face,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [vxao_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [vxao_pkg::LEVEL_BITS-1:0]     cfg_data
);
    import vxao_pkg::*;

    // level registers
    vxao_levels_t                levels_reg;

    // voxel hold stage
    logic [FACES-1:0]            pend_reg;
    logic [FACES-1:0]            pend_next;
    logic signed [POS_BITS-1:0]  hx_reg;
    logic signed [POS_BITS-1:0]  hy_reg;
    logic signed [POS_BITS-1:0]  hz_reg;
    logic [KIND_BITS-1:0]        hkind_reg;
    logic                        htransp_reg;
    logic                        hglow_reg;
    logic [NB_CELLS-1:0]         hmask_reg;

    // face result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [POS_BITS-1:0]  ox_reg;
    logic signed [POS_BITS-1:0]  oy_reg;
    logic signed [POS_BITS-1:0]  oz_reg;
    logic [KIND_BITS-1:0]        okind_reg;
    logic [FACE_BITS-1:0]        oface_reg;
    logic [CORNERS*CODE_BITS-1:0] ocodes_reg;
    logic                        oflip_reg;
    logic                        otransp_reg;
    logic                        oglow_reg;
    logic                        olast_reg;

    logic                        accept;
    logic                        advance;
    logic                        emit;
    logic                        voxel_gives_faces;
    logic [FACES-1:0]            vis_in;
    logic [FACES-1:0]            pend_rest;
    logic [FACE_BITS-1:0]        face_sel;
    logic [CORNERS*CODE_BITS-1:0] sh_codes;
    logic                        sh_flip;

    // visible faces of an incoming voxel
    assign voxel_gives_faces = !is_air && is_solid && is_cube;

    always_comb
    begin
        for (int f = 0; f < FACES; f++)
        begin
            vis_in[f] = voxel_gives_faces
                      && !(neighbour_solid_mask[FACE_NB[f]] && !face_transparent_mask[f]);
        end
    end

    // lowest pending face and what remains after it
    always_comb
    begin
        face_sel = '0;
        for (int f = FACES - 1; f >= 0; f--)
        begin
            if (pend_reg[f])
            begin
                face_sel = FACE_BITS'(f);
            end
        end
    end

    assign pend_rest = pend_reg & (pend_reg - FACES'(1));

    // handshake
    assign advance  = !out_valid_reg || out_ready;
    assign emit     = (pend_reg != '0) && advance;
    assign in_ready = (pend_reg == '0) || (advance && (pend_rest == '0));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            pend_next = vis_in;
        end
        else if (emit)
        begin
            pend_next = pend_rest;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    // shading of the selected face
    vxao_face_shade u_shade
    (
        .face          (face_sel),
        .nmask         (hmask_reg),
        .levels        (levels_reg),
        .ao_codes      (sh_codes),
        .flip_diagonal (sh_flip)
    );

    // control state and level registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg         <= '0;
            out_valid_reg    <= 1'b0;
            levels_reg.zero  <= LEVEL_ZERO_RST;
            levels_reg.one   <= LEVEL_ONE_RST;
            levels_reg.two   <= LEVEL_TWO_RST;
            levels_reg.three <= LEVEL_THREE_RST;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_LEVEL_ZERO:  levels_reg.zero  <= cfg_data;
                    REG_LEVEL_ONE:   levels_reg.one   <= cfg_data;
                    REG_LEVEL_TWO:   levels_reg.two   <= cfg_data;
                    REG_LEVEL_THREE: levels_reg.three <= cfg_data;
                    default:         levels_reg       <= levels_reg;
                endcase
            end
        end
    end

    // voxel payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hx_reg      <= world_x;
            hy_reg      <= world_y;
            hz_reg      <= world_z;
            hkind_reg   <= block_kind;
            htransp_reg <= is_transparent;
            hglow_reg   <= has_glow;
            hmask_reg   <= neighbour_solid_mask;
        end
    end

    // face payload capture
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ox_reg      <= hx_reg;
            oy_reg      <= hy_reg;
            oz_reg      <= hz_reg;
            okind_reg   <= hkind_reg;
            oface_reg   <= face_sel;
            ocodes_reg  <= sh_codes;
            oflip_reg   <= sh_flip;
            otransp_reg <= htransp_reg;
            oglow_reg   <= hglow_reg;
            olast_reg   <= (pend_rest == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_x           = ox_reg;
    assign out_y           = oy_reg;
    assign out_z           = oz_reg;
    assign out_kind        = okind_reg;
    assign face            = oface_reg;
    assign ao_codes        = ocodes_reg;
    assign flip_diagonal   = oflip_reg;
    assign out_transparent = otransp_reg;
    assign out_glow        = oglow_reg;
    assign last_face       = olast_reg;

    // a new voxel only overlaps the issue of the current last face
    `VXAO_ASSERT(a_accept_overlap, !(accept && (pend_reg != '0)) || (emit && (pend_rest == '0)))
    // every issued face lands in the output register
    `VXAO_ASSERT_NEXT(a_emit_fills_out, emit, out_valid_reg)
    // a blocked output freezes the pending face mask
    `VXAO_ASSERT_NEXT(a_stall_holds_mask, (pend_reg != '0) && !advance, $stable(pend_reg))
    // after the last face with no new voxel the hold stage is empty
    `VXAO_ASSERT_NEXT(a_last_empties, emit && (pend_rest == '0) && !accept, pend_reg == '0)

endmodule
